### rtl/sts_pkg.sv
// Shared types, token kind codes and character helpers for the token scanner.
package sts_pkg;

    localparam int OFFSET_BITS_DEF   = 16;
    localparam int KEYWORD_CHARS_DEF = 8;
    localparam int MAX_RES           = 4;
    localparam int NUM_KW            = 21;

    localparam logic [5:0] K_PLUS   = 6'd0;
    localparam logic [5:0] K_MINUS  = 6'd1;
    localparam logic [5:0] K_MUL    = 6'd2;
    localparam logic [5:0] K_DIV    = 6'd3;
    localparam logic [5:0] K_FDIV   = 6'd4;
    localparam logic [5:0] K_MOD    = 6'd5;
    localparam logic [5:0] K_POW    = 6'd6;
    localparam logic [5:0] K_BAND   = 6'd7;
    localparam logic [5:0] K_BOR    = 6'd8;
    localparam logic [5:0] K_BXOR   = 6'd9;
    localparam logic [5:0] K_LEN    = 6'd10;
    localparam logic [5:0] K_SEMI   = 6'd11;
    localparam logic [5:0] K_COMMA  = 6'd12;
    localparam logic [5:0] K_COLON  = 6'd13;
    localparam logic [5:0] K_LPAR   = 6'd14;
    localparam logic [5:0] K_RPAR   = 6'd15;
    localparam logic [5:0] K_LBRACE = 6'd16;
    localparam logic [5:0] K_RBRACE = 6'd17;
    localparam logic [5:0] K_LSQ    = 6'd18;
    localparam logic [5:0] K_RSQ    = 6'd19;
    localparam logic [5:0] K_ASSIGN = 6'd20;
    localparam logic [5:0] K_EQ     = 6'd21;
    localparam logic [5:0] K_NE     = 6'd22;
    localparam logic [5:0] K_GT     = 6'd23;
    localparam logic [5:0] K_GE     = 6'd24;
    localparam logic [5:0] K_SHR    = 6'd25;
    localparam logic [5:0] K_LT     = 6'd26;
    localparam logic [5:0] K_LE     = 6'd27;
    localparam logic [5:0] K_SHL    = 6'd28;
    localparam logic [5:0] K_DOT    = 6'd29;
    localparam logic [5:0] K_DOT2   = 6'd30;
    localparam logic [5:0] K_DOT3   = 6'd31;
    localparam logic [5:0] K_STRING = 6'd32;
    localparam logic [5:0] K_NUMBER = 6'd33;
    localparam logic [5:0] K_IDENT  = 6'd34;
    localparam logic [5:0] K_KW0    = 6'd35;
    localparam logic [5:0] K_EOF    = 6'd56;

    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_CHAR    = 2'd1;
    localparam logic [1:0] E_STRING  = 2'd2;
    localparam logic [1:0] E_COMMENT = 2'd3;

    typedef enum logic [4:0] {
        M_IDLE, M_SLASH, M_EQ, M_TILDE, M_GT, M_LT, M_DOT1, M_DOT2, M_DASH,
        M_LBRACK, M_STR, M_MSTR, M_MSTR_RB, M_CDASH, M_CBRACK, M_LINECOM,
        M_LCOM, M_LCOM_RB, M_NUM, M_NUMDOT, M_FRAC, M_IDENT
    } t_mode;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic [1:0]  err;
    } t_tok;

    typedef struct packed {
        logic [2:0] cnt;
        t_tok [MAX_RES-1:0] tok;
    } t_bundle;

    function automatic logic f_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic f_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    // single-byte operators that never need lookahead
    function automatic logic [6:0] f_single_op(input logic [7:0] c);
        logic [6:0] r;
        r = '0;
        case (c)
            "+": r = {1'b1, K_PLUS};
            "*": r = {1'b1, K_MUL};
            "%": r = {1'b1, K_MOD};
            "^": r = {1'b1, K_POW};
            "&": r = {1'b1, K_BAND};
            "|": r = {1'b1, K_BOR};
            "#": r = {1'b1, K_LEN};
            ";": r = {1'b1, K_SEMI};
            ",": r = {1'b1, K_COMMA};
            ":": r = {1'b1, K_COLON};
            "(": r = {1'b1, K_LPAR};
            ")": r = {1'b1, K_RPAR};
            "{": r = {1'b1, K_LBRACE};
            "}": r = {1'b1, K_RBRACE};
            "]": r = {1'b1, K_RSQ};
            default: r = '0;
        endcase
        return r;
    endfunction

    // keyword text, last char in the low byte
    function automatic logic [63:0] f_kw_word(input int k);
        logic [63:0] w;
        case (k)
            0: w = 64'("and");       1: w = 64'("break");
            2: w = 64'("do");        3: w = 64'("else");
            4: w = 64'("elseif");    5: w = 64'("end");
            6: w = 64'("false");     7: w = 64'("for");
            8: w = 64'("function");  9: w = 64'("if");
            10: w = 64'("in");       11: w = 64'("local");
            12: w = 64'("nil");      13: w = 64'("not");
            14: w = 64'("or");       15: w = 64'("repeat");
            16: w = 64'("return");   17: w = 64'("then");
            18: w = 64'("true");     19: w = 64'("until");
            20: w = 64'("while");
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] f_kw_len(input int k);
        logic [3:0] n;
        case (k)
            0, 5, 7, 12, 13: n = 4'd3;
            1, 6, 11, 19, 20: n = 4'd5;
            2, 9, 10, 14: n = 4'd2;
            3, 17, 18: n = 4'd4;
            4, 15, 16: n = 4'd6;
            8: n = 4'd8;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

### rtl/sts_if.sv
// Handshake channels: source bytes in, tokens out.
interface sts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       final_byte;
    modport source (output valid, char_byte, final_byte, input ready);
    modport sink (input valid, char_byte, final_byte, output ready);
endinterface

interface sts_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic [1:0]  error_code;
    logic        run_last;
    modport source (output valid, token_kind, token_start, token_length, line_number,
                    error_code, run_last, input ready);
    modport sink (input valid, token_kind, token_start, token_length, line_number,
                  error_code, run_last, output ready);
endinterface

### rtl/sts_core.sv
// Scanner state and per-byte token logic: one byte in, up to four tokens out.
module sts_core #(
    parameter int OFFSET_BITS   = sts_pkg::OFFSET_BITS_DEF,
    parameter int KEYWORD_CHARS = sts_pkg::KEYWORD_CHARS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_char,
    input  logic             i_final,
    output sts_pkg::t_bundle o_bundle
);
    localparam int KB = (KEYWORD_CHARS > 1) ? $clog2(KEYWORD_CHARS) : 1;
    typedef logic [KEYWORD_CHARS-1:0][7:0] t_buf;

    sts_pkg::t_mode         r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_ofs, n_ofs;
    logic [OFFSET_BITS-1:0] r_lstart, n_lstart;
    logic [15:0]            r_line, n_line;
    logic [15:0]            r_held, n_held;
    t_buf                   r_buf, n_buf;

    function automatic logic [5:0] f_ident(input t_buf b, input logic [15:0] held);
        logic [5:0]  k;
        logic        same;
        logic [63:0] w;
        logic [3:0]  n;
        k = sts_pkg::K_IDENT;
        if (held <= 16'(KEYWORD_CHARS)) begin
            for (int j = 0; j < sts_pkg::NUM_KW; j++) begin
                w = sts_pkg::f_kw_word(j);
                n = sts_pkg::f_kw_len(j);
                same = (16'(n) == held);
                for (int i = 0; i < 8; i++) begin
                    if (4'(i) < n && b[i] != w[(32'(n) - 1 - i) * 8 +: 8]) begin
                        same = 1'b0;
                    end
                end
                if (same) begin
                    k = sts_pkg::K_KW0 + 6'(j);
                end
            end
        end
        return k;
    endfunction

    function automatic sts_pkg::t_tok f_mk(input logic [5:0] kind,
                                           input logic [OFFSET_BITS-1:0] start,
                                           input logic [15:0] len, input logic [15:0] line,
                                           input logic [1:0] err);
        sts_pkg::t_tok t;
        t.kind  = kind;
        t.start = 16'(start);
        t.len   = len;
        t.line  = line;
        t.err   = err;
        return t;
    endfunction

    always_comb begin
        logic                   go, pf;
        logic [5:0]             pk;
        logic [1:0]             pe;
        logic [OFFSET_BITS-1:0] ps, pos, np;
        logic [15:0]            pl;
        logic [6:0]             op;
        logic [7:0]             c;
        logic [2:0]             cnt;
        sts_pkg::t_tok [sts_pkg::MAX_RES-1:0] res;

        n_mode   = r_mode;
        n_lstart = r_lstart;
        n_line   = r_line;
        n_held   = r_held;
        n_buf    = r_buf;
        c   = i_char;
        pos = r_ofs;
        np  = pos + 1'b1;
        cnt = '0;
        res = '0;
        op  = '0;
        go  = 1'b1;
        // a byte can fall through at most three modes (number, dot, idle)
        for (int it = 0; it < 4; it++) begin
            if (go) begin
                go = 1'b0;
                pf = 1'b0;
                pk = '0;
                pe = sts_pkg::E_NONE;
                ps = n_lstart;
                pl = n_held;
                case (n_mode)
                    sts_pkg::M_IDLE: begin
                        n_lstart = pos;
                        n_held   = 16'd1;
                        ps = pos;
                        pl = 16'd1;
                        op = sts_pkg::f_single_op(c);
                        if (op[6]) begin
                            pf = 1'b1;
                            pk = op[5:0];
                        end else begin
                            case (c)
                                "/": n_mode = sts_pkg::M_SLASH;
                                "=": n_mode = sts_pkg::M_EQ;
                                "~": n_mode = sts_pkg::M_TILDE;
                                ">": n_mode = sts_pkg::M_GT;
                                "<": n_mode = sts_pkg::M_LT;
                                ".": n_mode = sts_pkg::M_DOT1;
                                "-": n_mode = sts_pkg::M_DASH;
                                "[": n_mode = sts_pkg::M_LBRACK;
                                "\"": n_mode = sts_pkg::M_STR;
                                " ", "\r", "\t": ;
                                "\n": if (n_line != 16'hFFFF) n_line = n_line + 16'd1;
                                default: begin
                                    if (sts_pkg::f_digit(c)) begin
                                        n_mode = sts_pkg::M_NUM;
                                    end else if (sts_pkg::f_alpha(c)) begin
                                        n_buf[0] = c;
                                        n_mode = sts_pkg::M_IDENT;
                                    end else begin
                                        pf = 1'b1;
                                        pe = sts_pkg::E_CHAR;
                                    end
                                end
                            endcase
                        end
                    end
                    sts_pkg::M_SLASH, sts_pkg::M_EQ, sts_pkg::M_TILDE,
                    sts_pkg::M_GT, sts_pkg::M_LT, sts_pkg::M_DOT2: begin
                        pf = 1'b1;
                        go = 1'b1;
                        case (n_mode)
                            sts_pkg::M_SLASH: pk = sts_pkg::K_DIV;
                            sts_pkg::M_EQ:    pk = sts_pkg::K_ASSIGN;
                            sts_pkg::M_TILDE: pk = sts_pkg::K_BXOR;
                            sts_pkg::M_GT:    pk = sts_pkg::K_GT;
                            sts_pkg::M_LT:    pk = sts_pkg::K_LT;
                            default:          pk = sts_pkg::K_DOT2;
                        endcase
                        if (n_mode == sts_pkg::M_SLASH && c == "/") begin
                            pk = sts_pkg::K_FDIV; go = 1'b0;
                        end else if (c == "=" && (n_mode == sts_pkg::M_EQ)) begin
                            pk = sts_pkg::K_EQ; go = 1'b0;
                        end else if (c == "=" && (n_mode == sts_pkg::M_TILDE)) begin
                            pk = sts_pkg::K_NE; go = 1'b0;
                        end else if (c == "=" && (n_mode == sts_pkg::M_GT)) begin
                            pk = sts_pkg::K_GE; go = 1'b0;
                        end else if (c == ">" && (n_mode == sts_pkg::M_GT)) begin
                            pk = sts_pkg::K_SHR; go = 1'b0;
                        end else if (c == "=" && (n_mode == sts_pkg::M_LT)) begin
                            pk = sts_pkg::K_LE; go = 1'b0;
                        end else if (c == "<" && (n_mode == sts_pkg::M_LT)) begin
                            pk = sts_pkg::K_SHL; go = 1'b0;
                        end else if (c == "." && (n_mode == sts_pkg::M_DOT2)) begin
                            pk = sts_pkg::K_DOT3; go = 1'b0;
                        end
                        if (!go && n_held != 16'hFFFF) n_held = n_held + 16'd1;
                        pl = n_held;
                        n_mode = sts_pkg::M_IDLE;
                    end
                    sts_pkg::M_DOT1, sts_pkg::M_DASH, sts_pkg::M_LBRACK: begin
                        if ((n_mode == sts_pkg::M_DOT1 && c == ".") ||
                            (n_mode == sts_pkg::M_DASH && c == "-") ||
                            (n_mode == sts_pkg::M_LBRACK && c == "[")) begin
                            if (n_held != 16'hFFFF) n_held = n_held + 16'd1;
                            case (n_mode)
                                sts_pkg::M_DOT1: n_mode = sts_pkg::M_DOT2;
                                sts_pkg::M_DASH: n_mode = sts_pkg::M_CDASH;
                                default:         n_mode = sts_pkg::M_MSTR;
                            endcase
                        end else begin
                            pf = 1'b1;
                            go = 1'b1;
                            case (n_mode)
                                sts_pkg::M_DOT1: pk = sts_pkg::K_DOT;
                                sts_pkg::M_DASH: pk = sts_pkg::K_MINUS;
                                default:         pk = sts_pkg::K_LSQ;
                            endcase
                            n_mode = sts_pkg::M_IDLE;
                        end
                    end
                    sts_pkg::M_STR, sts_pkg::M_MSTR, sts_pkg::M_MSTR_RB,
                    sts_pkg::M_LCOM, sts_pkg::M_LCOM_RB: begin
                        if (n_held != 16'hFFFF) n_held = n_held + 16'd1;
                        if (c == "\n" && n_line != 16'hFFFF) n_line = n_line + 16'd1;
                        pl = n_held;
                        case (n_mode)
                            sts_pkg::M_STR: if (c == "\"") begin
                                pf = 1'b1; pk = sts_pkg::K_STRING; n_mode = sts_pkg::M_IDLE;
                            end
                            sts_pkg::M_MSTR: if (c == "]") n_mode = sts_pkg::M_MSTR_RB;
                            sts_pkg::M_MSTR_RB: if (c == "]") begin
                                pf = 1'b1; pk = sts_pkg::K_STRING; n_mode = sts_pkg::M_IDLE;
                            end else begin
                                n_mode = sts_pkg::M_MSTR;
                            end
                            sts_pkg::M_LCOM: if (c == "]") n_mode = sts_pkg::M_LCOM_RB;
                            default: n_mode = (c == "]") ? sts_pkg::M_IDLE : sts_pkg::M_LCOM;
                        endcase
                    end
                    sts_pkg::M_CDASH, sts_pkg::M_CBRACK: begin
                        if (c == "[") begin
                            if (n_held != 16'hFFFF) n_held = n_held + 16'd1;
                            n_mode = (n_mode == sts_pkg::M_CDASH) ? sts_pkg::M_CBRACK
                                                                  : sts_pkg::M_LCOM;
                        end else begin
                            n_mode = sts_pkg::M_LINECOM;
                            go = 1'b1;
                        end
                    end
                    sts_pkg::M_LINECOM: begin
                        if (c == "\n") begin
                            n_mode = sts_pkg::M_IDLE;
                            go = 1'b1;
                        end else if (n_held != 16'hFFFF) begin
                            n_held = n_held + 16'd1;
                        end
                    end
                    sts_pkg::M_NUM, sts_pkg::M_FRAC: begin
                        if (sts_pkg::f_digit(c)) begin
                            if (n_held != 16'hFFFF) n_held = n_held + 16'd1;
                        end else if (c == "." && n_mode == sts_pkg::M_NUM) begin
                            if (n_held != 16'hFFFF) n_held = n_held + 16'd1;
                            n_mode = sts_pkg::M_NUMDOT;
                        end else begin
                            pf = 1'b1; pk = sts_pkg::K_NUMBER; go = 1'b1;
                            n_mode = sts_pkg::M_IDLE;
                        end
                    end
                    sts_pkg::M_NUMDOT: begin
                        if (sts_pkg::f_digit(c)) begin
                            if (n_held != 16'hFFFF) n_held = n_held + 16'd1;
                            n_mode = sts_pkg::M_FRAC;
                        end else begin
                            // number without the dot; the dot restarts as its own lexeme
                            pf = 1'b1; pk = sts_pkg::K_NUMBER; go = 1'b1;
                            pl = (n_held == 16'hFFFF) ? 16'hFFFF : n_held - 16'd1;
                            n_lstart = pos - 1'b1;
                            n_held = 16'd1;
                            n_mode = sts_pkg::M_DOT1;
                        end
                    end
                    sts_pkg::M_IDENT: begin
                        if (sts_pkg::f_alpha(c) || sts_pkg::f_digit(c)) begin
                            if (n_held != 16'hFFFF) n_held = n_held + 16'd1;
                            if (n_held <= 16'(KEYWORD_CHARS)) begin
                                n_buf[KB'(n_held - 16'd1)] = c;
                            end
                        end else begin
                            pf = 1'b1; pk = f_ident(n_buf, n_held); go = 1'b1;
                            n_mode = sts_pkg::M_IDLE;
                        end
                    end
                    default: begin
                        n_mode = sts_pkg::M_IDLE;
                        go = 1'b1;
                    end
                endcase
                if (pf && cnt < 3'd4) begin
                    res[cnt[1:0]] = f_mk(pk, ps, pl, n_line, pe);
                    cnt = cnt + 3'd1;
                end
            end
        end

        n_ofs = np;
        if (i_final) begin
            pf = 1'b1;
            pe = sts_pkg::E_NONE;
            pk = '0;
            pl = n_held;
            case (n_mode)
                sts_pkg::M_SLASH:  pk = sts_pkg::K_DIV;
                sts_pkg::M_EQ:     pk = sts_pkg::K_ASSIGN;
                sts_pkg::M_TILDE:  pk = sts_pkg::K_BXOR;
                sts_pkg::M_GT:     pk = sts_pkg::K_GT;
                sts_pkg::M_LT:     pk = sts_pkg::K_LT;
                sts_pkg::M_DOT1:   pk = sts_pkg::K_DOT;
                sts_pkg::M_DOT2:   pk = sts_pkg::K_DOT2;
                sts_pkg::M_DASH:   pk = sts_pkg::K_MINUS;
                sts_pkg::M_LBRACK: pk = sts_pkg::K_LSQ;
                sts_pkg::M_STR, sts_pkg::M_MSTR, sts_pkg::M_MSTR_RB: pe = sts_pkg::E_STRING;
                sts_pkg::M_LCOM, sts_pkg::M_LCOM_RB: pe = sts_pkg::E_COMMENT;
                sts_pkg::M_NUM, sts_pkg::M_FRAC: pk = sts_pkg::K_NUMBER;
                sts_pkg::M_NUMDOT: begin
                    pk = sts_pkg::K_NUMBER;
                    pl = (n_held == 16'hFFFF) ? 16'hFFFF : n_held - 16'd1;
                end
                sts_pkg::M_IDENT:  pk = f_ident(n_buf, n_held);
                default: pf = 1'b0;
            endcase
            if (pf && cnt < 3'd4) begin
                res[cnt[1:0]] = f_mk(pk, n_lstart, pl, n_line, pe);
                cnt = cnt + 3'd1;
            end
            if (n_mode == sts_pkg::M_NUMDOT && cnt < 3'd4) begin
                res[cnt[1:0]] = f_mk(sts_pkg::K_DOT, pos, 16'd1, n_line, sts_pkg::E_NONE);
                cnt = cnt + 3'd1;
            end
            if (cnt < 3'd4) begin
                res[cnt[1:0]] = f_mk(sts_pkg::K_EOF, np, 16'd0, n_line, sts_pkg::E_NONE);
                cnt = cnt + 3'd1;
            end
            n_mode   = sts_pkg::M_IDLE;
            n_ofs    = '0;
            n_lstart = '0;
            n_line   = 16'd1;
            n_held   = '0;
        end
        o_bundle.cnt = cnt;
        o_bundle.tok = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= sts_pkg::M_IDLE;
            r_ofs    <= '0;
            r_lstart <= '0;
            r_line   <= 16'd1;
            r_held   <= '0;
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_ofs    <= n_ofs;
            r_lstart <= n_lstart;
            r_line   <= n_line;
            r_held   <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_buf <= n_buf;
        end
    end

endmodule

### rtl/script_token_scanner_top.sv
// Top level of the token scanner: byte input, result register, token output.
//
//  channel  | dir | payload                                               | accepted on
//  i_src    | in  | char_byte, final_byte                                 | valid & ready
//  o_tok    | out | token_kind, token_start, token_length, line_number,   | valid & ready
//           |     | error_code, run_last                                  |
//
// One byte is taken per cycle while no token waits or the last one is leaving; its
// tokens (zero to four) land together in a result register and leave one per cycle
// while o_tok is ready. The next byte is taken in the same cycle the last waiting
// token leaves. Reset (i_rst_n low at a clock edge) drops waiting tokens and returns
// the scanner to the start of a new text at line one. A stalled output holds its token.
module script_token_scanner_top #(
    parameter int OFFSET_BITS   = sts_pkg::OFFSET_BITS_DEF,
    parameter int KEYWORD_CHARS = sts_pkg::KEYWORD_CHARS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sts_byte_if.sink  i_src,
    sts_tok_if.source o_tok
);
    sts_pkg::t_bundle core_bundle;
    sts_pkg::t_tok [sts_pkg::MAX_RES-1:0] r_tok;
    logic [2:0] r_cnt;
    logic [1:0] r_idx;
    logic       take, out_beat, last_slot;
    sts_pkg::t_tok cur;

    assign last_slot = ({1'b0, r_idx} + 3'd1) == r_cnt;
    assign out_beat  = o_tok.valid && o_tok.ready;
    assign i_src.ready = (r_cnt == 3'd0) || (last_slot && o_tok.ready);
    assign take = i_src.valid && i_src.ready;

    sts_core #(
        .OFFSET_BITS  (OFFSET_BITS),
        .KEYWORD_CHARS(KEYWORD_CHARS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_char  (i_src.char_byte),
        .i_final (i_src.final_byte),
        .o_bundle(core_bundle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (take) begin
            r_cnt <= core_bundle.cnt;
            r_idx <= '0;
        end else if (out_beat) begin
            if (last_slot) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tok <= core_bundle.tok;
        end
    end

    assign cur = r_tok[r_idx];
    assign o_tok.valid        = r_cnt != 3'd0;
    assign o_tok.token_kind   = cur.kind;
    assign o_tok.token_start  = cur.start;
    assign o_tok.token_length = cur.len;
    assign o_tok.line_number  = cur.line;
    assign o_tok.error_code   = cur.err;
    assign o_tok.run_last     = last_slot;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.valid |-> ({1'b0, r_idx} < r_cnt))
        else $error("token index beyond waiting count");

    a_final_gives_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_src.final_byte) |=> (o_tok.valid && r_cnt != 3'd0))
        else $error("final byte produced no tokens");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.valid && !o_tok.ready) |-> !i_src.ready)
        else $error("input taken while a token is stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_tok.valid)
        else $error("tokens present after reset");

endmodule

### bench/testbench.sv
// Self-checking bench for the script token scanner: directed table, then random text.
`timescale 1ns / 1ps
module testbench;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic [1:0]  err;
        logic        last;
    } t_exp_tok;

    typedef struct {
        byte unsigned c;
        bit           fin;
        bit           has_exp;
        t_exp_tok     exp_tok;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sts_byte_if src_if ();
    sts_tok_if  tok_if ();

    script_token_scanner_top u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_src  (src_if.sink),
        .o_tok  (tok_if.source)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // scanner copy
    sts_pkg::t_mode lx_mode;
    logic [15:0]    lx_ofs;
    logic [15:0]    lx_start;
    logic [15:0]    lx_line;
    logic [7:0]     lx_ibuf [sts_pkg::KEYWORD_CHARS_DEF];
    logic [15:0]    lx_held;

    t_exp_tok expected_toks [$];
    t_exp_tok step_toks [$];
    int       fail_count = 0;

    function automatic void lx_reset();
        lx_mode  = sts_pkg::M_IDLE;
        lx_ofs   = '0;
        lx_start = '0;
        lx_line  = 16'd1;
        lx_held  = '0;
        for (int i = 0; i < sts_pkg::KEYWORD_CHARS_DEF; i++) lx_ibuf[i] = '0;
    endfunction

    function automatic string tok_text(t_exp_tok t);
        return $sformatf("k%0d s%0d n%0d l%0d e%0d r%0d",
                         t.kind, t.start, t.len, t.line, t.err, t.last);
    endfunction

    function automatic void emit_span(logic [5:0] k, logic [15:0] s, logic [15:0] n,
                                      logic [1:0] e);
        t_exp_tok t;
        if (step_toks.size() >= sts_pkg::MAX_RES) return;
        t.kind = k; t.start = s; t.len = n; t.line = lx_line; t.err = e; t.last = 1'b0;
        step_toks = {step_toks, t};
    endfunction

    function automatic void emit(logic [5:0] k, logic [1:0] e);
        emit_span(k, lx_start, lx_held, e);
    endfunction

    function automatic void grow();
        if (lx_held != 16'hFFFF) lx_held++;
    endfunction

    function automatic void count_nl(byte unsigned c);
        if (c == 8'h0A && lx_line != 16'hFFFF) lx_line++;
    endfunction

    function automatic bit is_dig(byte unsigned c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alp(byte unsigned c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [5:0] word_kind();
        string kw [21] = '{"and", "break", "do", "else", "elseif", "end", "false", "for",
            "function", "if", "in", "local", "nil", "not", "or", "repeat", "return",
            "then", "true", "until", "while"};
        bit same;
        if (lx_held > sts_pkg::KEYWORD_CHARS_DEF) return sts_pkg::K_IDENT;
        for (int k = 0; k < 21; k++) begin
            same = (kw[k].len() == lx_held);
            for (int i = 0; i < kw[k].len() && same; i++)
                if (kw[k][i] != lx_ibuf[i]) same = 0;
            if (same) return sts_pkg::K_KW0 + 6'(k);
        end
        return sts_pkg::K_IDENT;
    endfunction

    function automatic logic [15:0] num_len_less_dot();
        return (lx_held == 16'hFFFF) ? 16'hFFFF : lx_held - 16'd1;
    endfunction

    function automatic void scan_byte(byte unsigned c, logic [15:0] pos);
        bit again;
        logic [6:0] op;
        do begin
            again = 0;
            case (lx_mode)
                sts_pkg::M_IDLE: begin
                    lx_start = pos;
                    lx_held = 16'd1;
                    op = sts_pkg::f_single_op(c);
                    if (op[6]) emit(op[5:0], sts_pkg::E_NONE);
                    else case (c)
                        "/": lx_mode = sts_pkg::M_SLASH;
                        "=": lx_mode = sts_pkg::M_EQ;
                        "~": lx_mode = sts_pkg::M_TILDE;
                        ">": lx_mode = sts_pkg::M_GT;
                        "<": lx_mode = sts_pkg::M_LT;
                        ".": lx_mode = sts_pkg::M_DOT1;
                        "-": lx_mode = sts_pkg::M_DASH;
                        "[": lx_mode = sts_pkg::M_LBRACK;
                        "\"": lx_mode = sts_pkg::M_STR;
                        8'h20, 8'h0D, 8'h09: ;
                        8'h0A: count_nl(c);
                        default: begin
                            if (is_dig(c)) lx_mode = sts_pkg::M_NUM;
                            else if (is_alp(c)) begin
                                lx_ibuf[0] = c; lx_mode = sts_pkg::M_IDENT;
                            end else emit(6'd0, sts_pkg::E_CHAR);
                        end
                    endcase
                end
                sts_pkg::M_SLASH: begin
                    lx_mode = sts_pkg::M_IDLE;
                    if (c == "/") begin grow(); emit(sts_pkg::K_FDIV, sts_pkg::E_NONE); end
                    else begin emit(sts_pkg::K_DIV, sts_pkg::E_NONE); again = 1; end
                end
                sts_pkg::M_EQ: begin
                    lx_mode = sts_pkg::M_IDLE;
                    if (c == "=") begin grow(); emit(sts_pkg::K_EQ, sts_pkg::E_NONE); end
                    else begin emit(sts_pkg::K_ASSIGN, sts_pkg::E_NONE); again = 1; end
                end
                sts_pkg::M_TILDE: begin
                    lx_mode = sts_pkg::M_IDLE;
                    if (c == "=") begin grow(); emit(sts_pkg::K_NE, sts_pkg::E_NONE); end
                    else begin emit(sts_pkg::K_BXOR, sts_pkg::E_NONE); again = 1; end
                end
                sts_pkg::M_GT: begin
                    lx_mode = sts_pkg::M_IDLE;
                    if (c == "=") begin grow(); emit(sts_pkg::K_GE, sts_pkg::E_NONE); end
                    else if (c == ">") begin grow(); emit(sts_pkg::K_SHR, sts_pkg::E_NONE); end
                    else begin emit(sts_pkg::K_GT, sts_pkg::E_NONE); again = 1; end
                end
                sts_pkg::M_LT: begin
                    lx_mode = sts_pkg::M_IDLE;
                    if (c == "=") begin grow(); emit(sts_pkg::K_LE, sts_pkg::E_NONE); end
                    else if (c == "<") begin grow(); emit(sts_pkg::K_SHL, sts_pkg::E_NONE); end
                    else begin emit(sts_pkg::K_LT, sts_pkg::E_NONE); again = 1; end
                end
                sts_pkg::M_DOT1: begin
                    if (c == ".") begin grow(); lx_mode = sts_pkg::M_DOT2; end
                    else begin
                        lx_mode = sts_pkg::M_IDLE; emit(sts_pkg::K_DOT, sts_pkg::E_NONE);
                        again = 1;
                    end
                end
                sts_pkg::M_DOT2: begin
                    lx_mode = sts_pkg::M_IDLE;
                    if (c == ".") begin grow(); emit(sts_pkg::K_DOT3, sts_pkg::E_NONE); end
                    else begin emit(sts_pkg::K_DOT2, sts_pkg::E_NONE); again = 1; end
                end
                sts_pkg::M_DASH: begin
                    if (c == "-") begin grow(); lx_mode = sts_pkg::M_CDASH; end
                    else begin
                        lx_mode = sts_pkg::M_IDLE; emit(sts_pkg::K_MINUS, sts_pkg::E_NONE);
                        again = 1;
                    end
                end
                sts_pkg::M_LBRACK: begin
                    if (c == "[") begin grow(); lx_mode = sts_pkg::M_MSTR; end
                    else begin
                        lx_mode = sts_pkg::M_IDLE; emit(sts_pkg::K_LSQ, sts_pkg::E_NONE);
                        again = 1;
                    end
                end
                sts_pkg::M_STR: begin
                    grow(); count_nl(c);
                    if (c == "\"") begin
                        emit(sts_pkg::K_STRING, sts_pkg::E_NONE); lx_mode = sts_pkg::M_IDLE;
                    end
                end
                sts_pkg::M_MSTR: begin
                    grow(); count_nl(c);
                    if (c == "]") lx_mode = sts_pkg::M_MSTR_RB;
                end
                sts_pkg::M_MSTR_RB: begin
                    grow(); count_nl(c);
                    if (c == "]") begin
                        emit(sts_pkg::K_STRING, sts_pkg::E_NONE); lx_mode = sts_pkg::M_IDLE;
                    end
                    else lx_mode = sts_pkg::M_MSTR;
                end
                sts_pkg::M_CDASH: begin
                    if (c == "[") begin grow(); lx_mode = sts_pkg::M_CBRACK; end
                    else begin lx_mode = sts_pkg::M_LINECOM; again = 1; end
                end
                sts_pkg::M_CBRACK: begin
                    if (c == "[") begin grow(); lx_mode = sts_pkg::M_LCOM; end
                    else begin lx_mode = sts_pkg::M_LINECOM; again = 1; end
                end
                sts_pkg::M_LINECOM: begin
                    if (c == 8'h0A) begin lx_mode = sts_pkg::M_IDLE; again = 1; end
                    else grow();
                end
                sts_pkg::M_LCOM: begin
                    grow(); count_nl(c);
                    if (c == "]") lx_mode = sts_pkg::M_LCOM_RB;
                end
                sts_pkg::M_LCOM_RB: begin
                    grow(); count_nl(c);
                    lx_mode = (c == "]") ? sts_pkg::M_IDLE : sts_pkg::M_LCOM;
                end
                sts_pkg::M_NUM: begin
                    if (is_dig(c)) grow();
                    else if (c == ".") begin grow(); lx_mode = sts_pkg::M_NUMDOT; end
                    else begin
                        lx_mode = sts_pkg::M_IDLE; emit(sts_pkg::K_NUMBER, sts_pkg::E_NONE);
                        again = 1;
                    end
                end
                sts_pkg::M_NUMDOT: begin
                    if (is_dig(c)) begin grow(); lx_mode = sts_pkg::M_FRAC; end
                    else begin
                        // number ends before the dot; dot restarts as an operator
                        emit_span(sts_pkg::K_NUMBER, lx_start, num_len_less_dot(),
                                  sts_pkg::E_NONE);
                        lx_start = pos - 16'd1;
                        lx_held = 16'd1;
                        lx_mode = sts_pkg::M_DOT1;
                        again = 1;
                    end
                end
                sts_pkg::M_FRAC: begin
                    if (is_dig(c)) grow();
                    else begin
                        lx_mode = sts_pkg::M_IDLE; emit(sts_pkg::K_NUMBER, sts_pkg::E_NONE);
                        again = 1;
                    end
                end
                sts_pkg::M_IDENT: begin
                    if (is_alp(c) || is_dig(c)) begin
                        grow();
                        if (lx_held <= sts_pkg::KEYWORD_CHARS_DEF) lx_ibuf[lx_held - 1] = c;
                    end else begin
                        lx_mode = sts_pkg::M_IDLE; emit(word_kind(), sts_pkg::E_NONE);
                        again = 1;
                    end
                end
                default: begin lx_mode = sts_pkg::M_IDLE; again = 1; end
            endcase
        end while (again);
    endfunction

    function automatic void flush_text();
        case (lx_mode)
            sts_pkg::M_SLASH:  emit(sts_pkg::K_DIV, sts_pkg::E_NONE);
            sts_pkg::M_EQ:     emit(sts_pkg::K_ASSIGN, sts_pkg::E_NONE);
            sts_pkg::M_TILDE:  emit(sts_pkg::K_BXOR, sts_pkg::E_NONE);
            sts_pkg::M_GT:     emit(sts_pkg::K_GT, sts_pkg::E_NONE);
            sts_pkg::M_LT:     emit(sts_pkg::K_LT, sts_pkg::E_NONE);
            sts_pkg::M_DOT1:   emit(sts_pkg::K_DOT, sts_pkg::E_NONE);
            sts_pkg::M_DOT2:   emit(sts_pkg::K_DOT2, sts_pkg::E_NONE);
            sts_pkg::M_DASH:   emit(sts_pkg::K_MINUS, sts_pkg::E_NONE);
            sts_pkg::M_LBRACK: emit(sts_pkg::K_LSQ, sts_pkg::E_NONE);
            sts_pkg::M_STR, sts_pkg::M_MSTR, sts_pkg::M_MSTR_RB:
                emit(6'd0, sts_pkg::E_STRING);
            sts_pkg::M_LCOM, sts_pkg::M_LCOM_RB: emit(6'd0, sts_pkg::E_COMMENT);
            sts_pkg::M_NUM, sts_pkg::M_FRAC: emit(sts_pkg::K_NUMBER, sts_pkg::E_NONE);
            sts_pkg::M_NUMDOT: begin
                emit_span(sts_pkg::K_NUMBER, lx_start, num_len_less_dot(), sts_pkg::E_NONE);
                emit_span(sts_pkg::K_DOT, lx_ofs - 16'd1, 16'd1, sts_pkg::E_NONE);
            end
            sts_pkg::M_IDENT: emit(word_kind(), sts_pkg::E_NONE);
            default: ;
        endcase
    endfunction

    // predicts tokens for one byte into step_toks
    function automatic void predict_tokens(byte unsigned c, bit fin);
        logic [15:0] pos;
        step_toks.delete();
        pos = lx_ofs;
        scan_byte(c, pos);
        lx_ofs = pos + 16'd1;
        if (fin) begin
            flush_text();
            emit_span(sts_pkg::K_EOF, lx_ofs, 16'd0, sts_pkg::E_NONE);
            lx_reset();
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    endfunction

    task automatic send_byte(byte unsigned c, bit fin, bit has_exp, t_exp_tok exp_tok);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            src_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        predict_tokens(c, fin);
        if (has_exp && (step_toks.size() != 1 || step_toks[0] != exp_tok)) begin
            fail_count++;
            if (fail_count <= 10)
                $display("table row for byte %02h exp %s got %s", c, tok_text(exp_tok),
                         (step_toks.size() > 0) ? tok_text(step_toks[0]) : "none");
        end
        expected_toks = {expected_toks, step_toks};
        src_if.valid      <= 1'b1;
        src_if.char_byte  <= c;
        src_if.final_byte <= fin;
        do @(posedge i_clk); while (!src_if.ready);
    endtask

    // sink: random stalls, then compare each beat with the oldest expectation
    initial begin
        int stall;
        t_exp_tok got, want;
        tok_if.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                tok_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            tok_if.ready <= 1'b1;
            do @(posedge i_clk); while (!tok_if.valid);
            got.kind = tok_if.token_kind;   got.start = tok_if.token_start;
            got.len = tok_if.token_length;  got.line = tok_if.line_number;
            got.err = tok_if.error_code;    got.last = tok_if.run_last;
            if (expected_toks.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("unexpected token %s", tok_text(got));
            end else begin
                want = expected_toks.pop_front();
                if (got != want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch exp %s got %s", tok_text(want), tok_text(got));
                end
            end
        end
    end

    function automatic t_exp_tok mk(logic [5:0] k, logic [15:0] s, logic [15:0] n,
                                    logic [15:0] l, logic [1:0] e);
        t_exp_tok t;
        t.kind = k; t.start = s; t.len = n; t.line = l; t.err = e; t.last = 1'b1;
        return t;
    endfunction

    function automatic t_row rw(byte unsigned c, bit fin = 0);
        t_row r;
        r.c = c; r.fin = fin; r.has_exp = 0; r.exp_tok = '0;
        return r;
    endfunction

    function automatic t_row rx(byte unsigned c, t_exp_tok t, bit fin = 0);
        t_row r;
        r.c = c; r.fin = fin; r.has_exp = 1; r.exp_tok = t;
        return r;
    endfunction

    task automatic send_text(string s, bit end_it);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], end_it && i == s.len() - 1, 0, '0);
    endtask

    function automatic string rand_piece();
        string ops [] = '{"+", "-", "*", "/", "//", "%", "^", "&", "|", "~", "~=", "#",
            ";", ",", ":", "(", ")", "{", "}", "[", "]", "=", "==", ">", ">=", ">>", "<",
            "<=", "<<", ".", "..", "...", "and", "elseif", "function", "while", "x_9",
            "repeat", "longidentifier", "12", "3.25", "7.", "1..", "\"a b\"", "[[s]]",
            "[[a]b]]", "--c\n", "--[[x]y]]", "\"q\nq\"", "\n", " ", "\t", "\r", "9.x"};
        string s;
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) begin
            s = " ";
            s[0] = 8'($urandom_range(0, 255));
            return s;
        end
        return {ops[$urandom_range(0, ops.size() - 1)],
                ($urandom_range(0, 2) == 0) ? " " : ""};
    endfunction

    t_row  dir_rows [$];
    int    n_sent;
    string txt;

    initial begin
        src_if.valid = 1'b0;
        src_if.char_byte = 8'h00;
        src_if.final_byte = 1'b0;
        lx_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_rows = '{
            rx(8'h00, mk(6'd0, 16'd0, 16'd1, 16'd1, sts_pkg::E_CHAR)),
            rx(8'hFF, mk(6'd0, 16'd1, 16'd1, 16'd1, sts_pkg::E_CHAR)),
            rx("+", mk(sts_pkg::K_PLUS, 16'd2, 16'd1, 16'd1, sts_pkg::E_NONE)),
            rw("/"), rw("/"), rw("="), rw("="), rw("~"), rw("x"), rw("<"), rw("<"),
            rw(">"), rw("="), rw("1"), rw("."), rw(","), rw("."), rw("."), rw("."),
            rw("\n"), rw("\""), rw("a"), rw("\n", 1)
        };
        foreach (dir_rows[i])
            send_byte(dir_rows[i].c, dir_rows[i].fin, dir_rows[i].has_exp,
                      dir_rows[i].exp_tok);
        send_text("--[[a]", 1);
        send_text("[[s]", 1);
        send_text("7.", 1);
        send_text("function", 1);

        n_sent = 0;
        while (n_sent < 115) begin
            txt = rand_piece();
            send_text(txt, ($urandom_range(0, 15) == 0));
            n_sent += txt.len();
        end
        send_text(" ", 1);
        src_if.valid <= 1'b0;

        wait (expected_toks.size() == 0);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #4ms;
        $display("FAIL");
        $finish;
    end
endmodule

### filelist.f
rtl/sts_pkg.sv
rtl/sts_if.sv
rtl/sts_core.sv
rtl/script_token_scanner_top.sv
bench/testbench.sv
